### design/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator package
// Shared constants, result codes and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bra_pkg;

  // Ownership memory geometry
  localparam int MEM_BLOCKS = 1024;
  localparam int ADDR_W     = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;

  // Field widths
  localparam int ID_W    = 10;
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int MARK_W  = 11;
  localparam int END_W   = 12;   // start + count, never exceeds 3070
  localparam int CFG_IDX_W = 1;

  localparam logic [MARK_W-1:0] MARK_MAX = {MARK_W{1'b1}};

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_RT_FULL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_FULL = 1'd1;
  localparam logic [MARK_W-1:0]    RT_FULL_RST   = 11'd64;
  localparam logic [MARK_W-1:0]    USER_FULL_RST = 11'd1024;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BUSY   = 2'd2,
    ST_BOUNDS = 2'd3
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    clear;       // clearing pass: write zero at the sweep counter
    logic    load;        // capture the accepted request
    logic    scan_rd;     // read the block at the pointer, advance pointer
    logic    ptr_reload;  // pointer back to the start block
    logic    wr;          // write owner id at the pointer, advance pointer
    logic    commit;      // update the class end mark
    logic    out_load;    // load the result register
    status_e status;      // result code for out_load
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_done;     // sweep counter at the last entry
    logic full;           // class end mark equals its full mark
    logic bounds;         // range runs past the memory
    logic at_end;         // pointer reached start + count
    logic rd_pend;        // a scan read is returning this cycle
    logic busy_hit;       // returning read shows an owned block
  } sts_t;

endpackage

### design/bra_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation request channel
// Valid/ready channel carrying one allocation request per item.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic                        valid;
  logic                        ready;
  logic [bra_pkg::ID_W-1:0]    owner_id;
  logic                        is_realtime;
  logic [bra_pkg::START_W-1:0] start_block;
  logic [bra_pkg::COUNT_W-1:0] block_count;
  logic                        batch_end;

  modport source (
    output valid, owner_id, is_realtime, start_block, block_count, batch_end,
    input  ready
  );
  modport sink (
    input  valid, owner_id, is_realtime, start_block, block_count, batch_end,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// Allocation result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [bra_pkg::ID_W-1:0] owner_echo;
  logic                     batch_done;

  modport source (
    output valid, status, owner_echo, batch_done,
    input  ready
  );
  modport sink (
    input  valid, status, owner_echo, batch_done,
    output ready
  );
endinterface

### design/bra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator datapath
// Request registers, config registers, class end marks, range pointer,
// ownership memory and the result register.
// ----------------------------------------------------------------------------
module bra_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bra_pkg::MARK_W-1:0]   cfg_data_i,
  // request payload
  input  logic [bra_pkg::ID_W-1:0]     owner_id_i,
  input  logic                         is_realtime_i,
  input  logic [bra_pkg::START_W-1:0]  start_block_i,
  input  logic [bra_pkg::COUNT_W-1:0]  block_count_i,
  input  logic                         batch_end_i,
  // controller link
  input  bra_pkg::cmd_t                cmd_i,
  output bra_pkg::sts_t                sts_o,
  // result payload
  output logic [1:0]                   status_o,
  output logic [bra_pkg::ID_W-1:0]     owner_echo_o,
  output logic                         batch_done_o
);

  localparam int AW = bra_pkg::ADDR_W;

  logic [bra_pkg::MARK_W-1:0]  rt_full_q, user_full_q;
  logic [bra_pkg::MARK_W-1:0]  rt_end_q, user_end_q;
  logic [bra_pkg::ID_W-1:0]    id_q;
  logic                        rt_q;
  logic                        last_q;
  logic [bra_pkg::END_W-1:0]   start_q;
  logic [bra_pkg::END_W-1:0]   end_q;
  logic [bra_pkg::END_W-1:0]   ptr_q;
  logic [AW-1:0]               clr_cnt_q;
  logic                        rd_vld_q;
  logic [bra_pkg::ID_W-1:0]    rdata_q;
  logic [bra_pkg::ID_W-1:0]    mem [bra_pkg::MEM_BLOCKS];
  logic [bra_pkg::END_W-1:0]   end_d;
  logic [bra_pkg::MARK_W-1:0]  mark_sat;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [bra_pkg::ID_W-1:0]    mem_wdata;
  logic [1:0]                  status_q;
  logic [bra_pkg::ID_W-1:0]    echo_q;
  logic                        done_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_full_q   <= bra_pkg::RT_FULL_RST;
      user_full_q <= bra_pkg::USER_FULL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bra_pkg::CFG_RT_FULL:   rt_full_q   <= cfg_data_i;
        bra_pkg::CFG_USER_FULL: user_full_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request capture
  assign end_d = bra_pkg::END_W'(start_block_i) + bra_pkg::END_W'(block_count_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= owner_id_i;
      rt_q    <= is_realtime_i;
      last_q  <= batch_end_i;
      start_q <= bra_pkg::END_W'(start_block_i);
      end_q   <= end_d;
    end
  end

  // Range pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ptr_q <= bra_pkg::END_W'(start_block_i);
    end else if (cmd_i.ptr_reload) begin
      ptr_q <= start_q;
    end else if (cmd_i.scan_rd || cmd_i.wr) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  // Class end marks, saturated
  assign mark_sat = (end_q > bra_pkg::END_W'(bra_pkg::MARK_MAX)) ?
                    bra_pkg::MARK_MAX : end_q[bra_pkg::MARK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_end_q   <= '0;
      user_end_q <= '0;
    end else if (cmd_i.commit) begin
      if (rt_q) begin
        rt_end_q <= mark_sat;
      end else begin
        user_end_q <= mark_sat;
      end
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Ownership memory: one write port, one registered read port
  assign mem_we    = cmd_i.clear || cmd_i.wr;
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : AW'(ptr_q);
  assign mem_wdata = cmd_i.clear ? '0 : id_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.scan_rd) begin
      rdata_q <= mem[AW'(ptr_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= 2'(cmd_i.status);
      echo_q   <= id_q;
      done_q   <= last_q;
    end
  end

  assign status_o     = status_q;
  assign owner_echo_o = echo_q;
  assign batch_done_o = done_q;

  // Status to the controller
  always_comb begin
    sts_o.clear_done = (clr_cnt_q == AW'(bra_pkg::MEM_BLOCKS - 1));
    sts_o.full       = rt_q ? (rt_end_q == rt_full_q) : (user_end_q == user_full_q);
    sts_o.bounds     = (32'(end_q) > bra_pkg::MEM_BLOCKS);
    sts_o.at_end     = (ptr_q == end_q);
    sts_o.rd_pend    = rd_vld_q;
    sts_o.busy_hit   = rd_vld_q && (rdata_q != '0);
  end

endmodule

### design/bra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator controller
// Sequences clearing, checks, the occupancy scan, the write pass and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module bra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  bra_pkg::sts_t sts_i,
  output bra_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]       state_q, state_d;
  bra_pkg::status_e status_q, status_d;
  logic             out_vld_q, out_vld_d;
  logic             out_free;

  assign out_free    = !out_vld_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_vld_q;

  // Next state and command decode
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.full) begin
          status_d = bra_pkg::ST_FULL;
          state_d  = S_RESP;
        end else if (sts_i.bounds) begin
          status_d = bra_pkg::ST_BOUNDS;
          state_d  = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads stream one per cycle, data checked in the following cycle
        if (sts_i.busy_hit) begin
          status_d = bra_pkg::ST_BUSY;
          state_d  = S_RESP;
        end else if (sts_i.at_end && !sts_i.rd_pend) begin
          cmd_o.ptr_reload = 1'b1;
          state_d          = S_WRITE;
        end else if (!sts_i.at_end) begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_WRITE: begin
        if (sts_i.at_end) begin
          cmd_o.commit = 1'b1;
          status_d     = bra_pkg::ST_OK;
          state_d      = S_RESP;
        end else begin
          cmd_o.wr = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      status_q  <= bra_pkg::ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

### design/block_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator
// Grants or refuses block ranges of an ownership memory, one request at a
// time, and returns one result item for each request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req_i     in   valid/ready          owner_id, is_realtime, start_block,
//                                      block_count, batch_end
//  rsp_o     out  valid/ready          status, owner_echo, batch_done
//  cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
//  A granted request of n blocks is scanned and then written: the single read
//  and single write port of the ownership memory give one scanned block and
//  one written block per cycle. Refusals on class full or bounds skip both.
//  After reset a clearing pass writes all MEM_BLOCKS (1024) entries to free,
//  with req_i held not ready; config writes still land.
//  A result waits in an output register; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module block_range_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bra_pkg::MARK_W-1:0]    cfg_data_i,
  bra_req_if.sink                       req_i,
  bra_rsp_if.source                     rsp_o
);

  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  // Sequencer
  bra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  bra_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .owner_id_i    (req_i.owner_id),
    .is_realtime_i (req_i.is_realtime),
    .start_block_i (req_i.start_block),
    .block_count_i (req_i.block_count),
    .batch_end_i   (req_i.batch_end),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (rsp_o.status),
    .owner_echo_o  (rsp_o.owner_echo),
    .batch_done_o  (rsp_o.batch_done)
  );

endmodule

### design/bra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator port checker
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module bra_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     req_valid_i,
  input logic                     req_ready_i,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic [1:0]               rsp_status_i,
  input logic [bra_pkg::ID_W-1:0] rsp_owner_echo_i,
  input logic                     rsp_batch_done_i
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_owner_echo_i) && $stable(rsp_batch_done_i))
    else $error("result payload changed while stalled");

  // one request at a time: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is in work");

  // clearing pass holds requests off right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("request ready during the clearing pass");

endmodule

bind block_range_allocator bra_checker u_bra_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_owner_echo_i (rsp_o.owner_echo),
  .rsp_batch_done_i (rsp_o.batch_done)
);

### test/block_range_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block range allocator testbench
// Drives allocation requests with random gaps and checks every result item
// against an ownership-map predictor kept in a small scoreboard class.
// Directed requests cover zero counts, owner id zero, full classes,
// out-of-bounds ranges and occupied ranges. Random phases follow under
// changing full marks. One phase holds off the result side long enough for
// the request side to stall.
// ----------------------------------------------------------------------------
module block_range_allocator_tb;

  // Accepted request as seen on the request channel
  typedef struct packed {
    logic [bra_pkg::ID_W-1:0]    owner_id;
    logic                        is_realtime;
    logic [bra_pkg::START_W-1:0] start_block;
    logic [bra_pkg::COUNT_W-1:0] block_count;
    logic                        batch_end;
  } alloc_req_t;

  // Result item, expected or observed
  typedef struct packed {
    logic [1:0]               status;
    logic [bra_pkg::ID_W-1:0] owner;
    logic                     batch;
  } alloc_res_t;

  // Ownership map, class end marks and the results still owed by the block
  class alloc_ledger;
    logic [bra_pkg::ID_W-1:0]   owner_map [bra_pkg::MEM_BLOCKS];
    logic [bra_pkg::MARK_W-1:0] rt_end;
    logic [bra_pkg::MARK_W-1:0] user_end;
    logic [bra_pkg::MARK_W-1:0] rt_full;
    logic [bra_pkg::MARK_W-1:0] user_full;
    alloc_res_t                 due_results [$];
    int                         mismatches;

    function new();
      foreach (owner_map[b]) owner_map[b] = '0;
      rt_end     = '0;
      user_end   = '0;
      rt_full    = bra_pkg::RT_FULL_RST;
      user_full  = bra_pkg::USER_FULL_RST;
      mismatches = 0;
    endfunction

    // Decide the request and apply its effect: full, then bounds, then scan
    function void note_request(alloc_req_t r);
      logic [bra_pkg::END_W-1:0]  stop;
      logic [bra_pkg::MARK_W-1:0] cur;
      logic [bra_pkg::MARK_W-1:0] lim;
      bra_pkg::status_e           st;
      int                         b;
      stop = bra_pkg::END_W'(r.start_block) + bra_pkg::END_W'(r.block_count);
      cur  = r.is_realtime ? rt_end : user_end;
      lim  = r.is_realtime ? rt_full : user_full;
      if (cur == lim) begin
        st = bra_pkg::ST_FULL;
      end else if (int'(stop) > bra_pkg::MEM_BLOCKS) begin
        st = bra_pkg::ST_BOUNDS;
      end else begin
        st = bra_pkg::ST_OK;
        for (b = int'(r.start_block); b < int'(stop); b++)
          if (owner_map[b] != '0) st = bra_pkg::ST_BUSY;
        if (st == bra_pkg::ST_OK) begin
          for (b = int'(r.start_block); b < int'(stop); b++) owner_map[b] = r.owner_id;
          cur = (stop > bra_pkg::END_W'(bra_pkg::MARK_MAX)) ?
                bra_pkg::MARK_MAX : stop[bra_pkg::MARK_W-1:0];
          if (r.is_realtime) rt_end = cur;
          else user_end = cur;
        end
      end
      due_results.push_back('{status: st, owner: r.owner_id, batch: r.batch_end});
    endfunction

    function void check_result(alloc_res_t got);
      alloc_res_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none due: status %0d owner %0d batch %0d",
                   $time, got.status, got.owner, got.batch);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.owner !== want.owner ||
          got.batch !== want.batch) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d owner %0d batch %0d, got %0d %0d %0d",
                   $time, want.status, want.owner, want.batch,
                   got.status, got.owner, got.batch);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bra_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bra_pkg::MARK_W-1:0]    cfg_data_i;

  bra_req_if req_if ();
  bra_rsp_if rsp_if ();

  alloc_ledger ledger;
  bit req_idle_on;
  bit rsp_idle_on;
  int rsp_holdoff = 0;

  block_range_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Full mark choice: extremes, the current end (class full) or anything
  function automatic logic [bra_pkg::MARK_W-1:0] pick_mark(
      input logic [bra_pkg::MARK_W-1:0] cur_end);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return bra_pkg::MARK_W'(bra_pkg::MEM_BLOCKS);
    if (r < 4) return cur_end;
    return bra_pkg::MARK_W'($urandom_range(0, bra_pkg::MEM_BLOCKS));
  endfunction

  // Offer one request and return at the edge that accepts it
  task automatic send_alloc(input logic [bra_pkg::ID_W-1:0] id, input logic rt,
                            input logic [bra_pkg::START_W-1:0] start,
                            input logic [bra_pkg::COUNT_W-1:0] count,
                            input logic fin);
    int gap;
    gap = pick_gap(req_idle_on);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.owner_id    <= id;
    req_if.is_realtime <= rt;
    req_if.start_block <= start;
    req_if.block_count <= count;
    req_if.batch_end   <= fin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every owed result has come back;
  // the wait begins only once the last accepted item is already on the books
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both full marks on back-to-back edges
  task automatic write_marks(input logic [bra_pkg::MARK_W-1:0] rt_mark,
                             input logic [bra_pkg::MARK_W-1:0] user_mark);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bra_pkg::CFG_RT_FULL;
    cfg_data_i <= rt_mark;
    @(posedge clk_i);
    cfg_idx_i  <= bra_pkg::CFG_USER_FULL;
    cfg_data_i <= user_mark;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.rt_full   = rt_mark;
    ledger.user_full = user_mark;
  endtask

  // Request monitor feeds the predictor
  always @(posedge clk_i) begin
    alloc_req_t seen;
    if (rst_ni && req_if.valid && req_if.ready) begin
      seen = '{req_if.owner_id, req_if.is_realtime, req_if.start_block,
               req_if.block_count, req_if.batch_end};
      ledger.note_request(seen);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    alloc_res_t seen;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen = '{rsp_if.status, rsp_if.owner_echo, rsp_if.batch_done};
      ledger.check_result(seen);
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    forever begin
      if (rsp_holdoff > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_holdoff) @(posedge clk_i);
        rsp_holdoff = 0;
      end else begin
        gap = pick_gap(rsp_idle_on);
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
        while (!rsp_if.valid) @(posedge clk_i);
      end
    end
  end

  initial begin
    int                          phase;
    int                          n;
    int                          k;
    int                          kind;
    int                          w;
    logic [bra_pkg::ID_W-1:0]    id;
    logic                        rt;
    logic                        fin;
    logic [bra_pkg::START_W-1:0] start;
    logic [bra_pkg::COUNT_W-1:0] count;
    logic [bra_pkg::MARK_W-1:0]  mark;

    ledger = new();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= bra_pkg::CFG_RT_FULL;
    cfg_data_i         <= '0;
    req_if.valid       <= 1'b0;
    req_if.owner_id    <= '0;
    req_if.is_realtime <= 1'b0;
    req_if.start_block <= '0;
    req_if.block_count <= '0;
    req_if.batch_end   <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset marks: zero counts, user class filled to its mark, full before bounds
    send_alloc(10'd1,    1'b0, 10'd0,    11'd0,  1'b0);
    send_alloc(10'd2,    1'b1, 10'd0,    11'd0,  1'b1);
    send_alloc(10'd1023, 1'b0, 10'd1023, 11'd1,  1'b0);
    send_alloc(10'd5,    1'b0, 10'd1023, 11'd5,  1'b1);
    send_alloc(10'h2AA,  1'b1, 10'd0,    11'd64, 1'b0);
    send_alloc(10'd3,    1'b1, 10'd100,  11'd1,  1'b1);
    drain();

    // Zero marks: end marks past the mark are not full
    write_marks('0, '0);
    send_alloc(10'h155,  1'b0, 10'd1023, 11'd2,    1'b0);
    send_alloc(10'd4,    1'b0, 10'd0,    11'd1024, 1'b1);
    send_alloc(10'd6,    1'b1, 10'd512,  11'd1024, 1'b0);
    send_alloc(10'd0,    1'b0, 10'd200,  11'd8,    1'b0);
    send_alloc(10'd7,    1'b0, 10'd200,  11'd8,    1'b1);
    send_alloc(10'd8,    1'b1, 10'd1023, 11'd1024, 1'b0);
    send_alloc(10'd9,    1'b1, 10'd64,   11'd960,  1'b1);
    send_alloc(10'h155,  1'b0, 10'd300,  11'd1,    1'b0);
    send_alloc(10'd10,   1'b0, 10'd300,  11'd1,    1'b1);
    send_alloc(10'd1023, 1'b1, 10'd64,   11'd0,    1'b0);
    send_alloc(10'd11,   1'b1, 10'd0,    11'd1,    1'b1);
    drain();

    // User mark set to its current end
    write_marks(bra_pkg::MARK_W'(bra_pkg::MEM_BLOCKS), ledger.user_end);
    send_alloc(10'd12, 1'b0, 10'd400, 11'd1, 1'b0);
    send_alloc(10'd13, 1'b1, 10'd400, 11'd1, 1'b1);
    drain();

    // Random phases under changing marks
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 0) write_marks(bra_pkg::MARK_W'(bra_pkg::MEM_BLOCKS),
                                  bra_pkg::MARK_W'(bra_pkg::MEM_BLOCKS));
      else write_marks(pick_mark(ledger.rt_end), pick_mark(ledger.user_end));
      req_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      rsp_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      if (phase == 3) rsp_holdoff = 300;

      for (n = 0; n < 108; n++) begin
        kind = $urandom_range(0, 99);
        id   = ($urandom_range(0, 11) == 0) ? '0 : bra_pkg::ID_W'($urandom_range(1, 1023));
        rt   = 1'($urandom_range(0, 1));
        fin  = 1'($urandom_range(0, 1));
        start = bra_pkg::START_W'($urandom_range(0, 1023));
        if (kind < 55) begin
          // short range from the next free block
          for (k = 0; k < bra_pkg::MEM_BLOCKS && ledger.owner_map[start] != '0; k++)
            start++;
          count = ($urandom_range(0, 4) == 0) ? bra_pkg::COUNT_W'($urandom_range(4, 24))
                                              : bra_pkg::COUNT_W'($urandom_range(1, 3));
          if (start + count > bra_pkg::MEM_BLOCKS)
            count = bra_pkg::COUNT_W'(bra_pkg::MEM_BLOCKS - start);
        end else if (kind < 65) begin
          // range that ends right on the class mark
          mark  = rt ? ledger.rt_full : ledger.user_full;
          count = bra_pkg::COUNT_W'($urandom_range(0, 3));
          if (mark >= count && mark - count < bra_pkg::MEM_BLOCKS)
            start = bra_pkg::START_W'(mark - count);
        end else if (kind < 78) begin
          // range that starts on an owned block
          for (k = 0; k < bra_pkg::MEM_BLOCKS && ledger.owner_map[start] == '0; k++)
            start++;
          count = bra_pkg::COUNT_W'($urandom_range(1, 8));
        end else if (kind < 86) begin
          // range running past the memory
          start = bra_pkg::START_W'($urandom_range(900, 1023));
          count = bra_pkg::COUNT_W'($urandom_range(1025 - start, 1024));
        end else if (kind < 90) begin
          count = '0;
        end else begin
          count = bra_pkg::COUNT_W'($urandom_range(0, 1024));
        end
        send_alloc(id, rt, start, count, fin);
      end
      drain();
    end

    // Final wait, bounded
    req_if.valid <= 1'b0;
    for (w = 0; w < 100000 && ledger.pending() != 0; w++) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (ledger.pending() != 0)
      $display("%0d result items never arrived", ledger.pending());
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### block_range_allocator.f
design/bra_pkg.sv
design/bra_req_if.sv
design/bra_dp.sv
design/bra_ctrl.sv
design/block_range_allocator.sv
design/bra_checker.sv
test/block_range_allocator_tb.sv
